>>> src/cdad_pkg.sv
// ---------------------------------------------------------------------------
// cdad_pkg: shared types and constants for the calendar date stepper
// Month table, leap rule, status codes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package cdad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 16;

  localparam int CountBitsDefault = 16;

  localparam logic [YearW-1:0]  YearMin = 14'd1;
  localparam logic [YearW-1:0]  YearMax = 14'd9999;
  localparam logic [MonthW-1:0] MonJan  = 4'd1;
  localparam logic [MonthW-1:0] MonFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonDec  = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [DayW-1:0]   DayLast  = 5'd31;

  // floor(y / 100) == (y * Recip100) >> Recip100Shift for every y below 43690
  localparam int RecipW        = 13;
  localparam int Recip100Shift = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam int CentW    = 8;
  localparam int YModW    = 7;
  localparam logic [YModW-1:0] YModLast = 7'd99;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MOD,
    S_CHECK,
    S_WALK,
    S_DONE
  } state_t;

  // Leap year from year mod 100 and century mod 4.
  function automatic logic is_leap(input logic [YModW-1:0] ymod, input logic [1:0] cen);
    logic leap;
    if (ymod == '0) begin
      leap = (cen == 2'd0);
    end else begin
      leap = (ymod[1:0] == 2'd0);
    end
    return leap;
  endfunction

  // Length of a month; months outside 1..12 read as 31 and are screened elsewhere.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] n;
    unique case (m)
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> src/calendar_date_add_days.sv
// Sequence: after the accepting edge, divide by 100, take the remainder, check the date,
//   then walk month by month until the last walk step lands in the final month, and
//   load the result register; an invalid date skips the walk.
//   A full 65535-day move crosses about 2153 months.
// Requests: one at a time; req_stall holds off the next until idle, so the month walk sets the pace.
// Reset: rst (synchronous) returns the sequencer to idle and drops the result valid.
// ---------------------------------------------------------------------------
// calendar_date_add_days: move a Gregorian date forward or back by N days
// Walks month by month with a single step unit; flags invalid dates and
// saturates at 1 Jan 1 and 31 Dec 9999.
// ---------------------------------------------------------------------------
`default_nettype none

module calendar_date_add_days #(
  parameter int COUNT_BITS = cdad_pkg::CountBitsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          action,
  input  wire logic [cdad_pkg::DayW-1:0]     day,
  input  wire logic [cdad_pkg::MonthW-1:0]   month,
  input  wire logic [cdad_pkg::YearW-1:0]    year,
  input  wire logic [cdad_pkg::CountW-1:0]   count,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic [cdad_pkg::DayW-1:0]          result_day,
  output logic [cdad_pkg::MonthW-1:0]        result_month,
  output logic [cdad_pkg::YearW-1:0]         result_year,
  output logic [1:0]                         status
);
  import cdad_pkg::*;

  // Only the low COUNT_BITS bits of count matter, and the port has CountW of them.
  localparam int KW = (COUNT_BITS < CountW) ? COUNT_BITS : CountW;
  // Width that holds a day, a remaining count and their sum.
  localparam int SW = ((KW > DayW) ? KW : DayW) + 1;

  state_t state, state_next;

  logic               back, back_next;
  logic [DayW-1:0]    d, d_next;
  logic [MonthW-1:0]  m, m_next;
  logic [YearW-1:0]   y, y_next;
  logic [KW-1:0]      k, k_next;
  logic [CentW-1:0]   q, q_next;
  logic [YModW-1:0]   ymod, ymod_next;
  logic [1:0]         cen, cen_next;
  status_t            st, st_next;

  logic [RecipW+YearW-1:0] prod;
  logic [YearW-1:0]        qx100;
  logic [YearW-1:0]        rem;
  logic                    leap;
  logic [DayW-1:0]         n_cur;
  logic [SW-1:0]           d_ext, k_ext, n_ext, sum_ext, span_ext;
  logic                    load_res;

  // Year split for the leap rule: quotient by reciprocal, then remainder.
  assign prod  = (RecipW+YearW)'(y) * (RecipW+YearW)'(Recip100);
  assign qx100 = YearW'(q) * YearW'(100);
  assign rem   = y - qx100;

  assign leap     = is_leap(ymod, cen);
  assign n_cur    = month_days(m, leap);
  assign d_ext    = SW'(d);
  assign k_ext    = SW'(k);
  assign n_ext    = SW'(n_cur);
  assign sum_ext  = d_ext + k_ext;
  // Days left in this month including today: n - d + 1.
  assign span_ext = n_ext - d_ext + SW'(1);

  assign req_stall = (state != S_IDLE);
  // Load the result register once the previous result is gone or leaving.
  assign load_res  = (state == S_DONE) && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    back <= back_next;
    d    <= d_next;
    m    <= m_next;
    y    <= y_next;
    k    <= k_next;
    q    <= q_next;
    ymod <= ymod_next;
    cen  <= cen_next;
    st   <= st_next;
  end

  always_comb begin
    state_next = state;
    back_next  = back;
    d_next     = d;
    m_next     = m;
    y_next     = y;
    k_next     = k;
    q_next     = q;
    ymod_next  = ymod;
    cen_next   = cen;
    st_next    = st;

    unique case (state)
      S_IDLE: begin
        // Capture the request.
        if (req_valid) begin
          back_next  = action;
          d_next     = day;
          m_next     = month;
          y_next     = year;
          k_next     = count[KW-1:0];
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        q_next     = prod[Recip100Shift +: CentW];
        state_next = S_MOD;
      end
      S_MOD: begin
        ymod_next  = rem[YModW-1:0];
        cen_next   = q[1:0];
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // Reject a bad start date; the date passes through untouched.
        if (m < MonJan || m > MonDec || y < YearMin || y > YearMax ||
            d < DayFirst || d > n_cur) begin
          st_next    = ST_BAD_DATE;
          state_next = S_DONE;
        end else begin
          st_next    = ST_OK;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (!back) begin
          if (sum_ext <= n_ext) begin
            // Lands inside this month.
            d_next     = sum_ext[DayW-1:0];
            k_next     = '0;
            state_next = S_DONE;
          end else begin
            // Advance to the first of next month.
            k_next = KW'(k_ext - span_ext);
            d_next = DayFirst;
            if (m == MonDec) begin
              if (y == YearMax) begin
                d_next     = DayLast;
                m_next     = MonDec;
                st_next    = ST_RANGE;
                k_next     = '0;
                state_next = S_DONE;
              end else begin
                m_next = MonJan;
                y_next = y + YearW'(1);
                if (ymod == YModLast) begin
                  ymod_next = '0;
                  cen_next  = cen + 2'd1;
                end else begin
                  ymod_next = ymod + YModW'(1);
                end
              end
            end else begin
              m_next = m + MonthW'(1);
            end
          end
        end else begin
          if (d_ext > k_ext) begin
            d_next     = DayW'(d_ext - k_ext);
            k_next     = '0;
            state_next = S_DONE;
          end else begin
            // Drop back to the last day of the previous month.
            k_next = KW'(k_ext - d_ext);
            if (m == MonJan) begin
              if (y == YearMin) begin
                d_next     = DayFirst;
                m_next     = MonJan;
                st_next    = ST_RANGE;
                k_next     = '0;
                state_next = S_DONE;
              end else begin
                m_next = MonDec;
                d_next = DayLast;
                y_next = y - YearW'(1);
                if (ymod == '0) begin
                  ymod_next = YModLast;
                  cen_next  = cen - 2'd1;
                end else begin
                  ymod_next = ymod - YModW'(1);
                end
              end
            end else begin
              m_next = m - MonthW'(1);
              d_next = month_days(m - MonthW'(1), leap);
            end
          end
        end
      end
      S_DONE: begin
        if (load_res) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result_day   <= d;
      result_month <= m;
      result_year  <= y;
      status       <= st;
    end
  end

endmodule

`default_nettype wire
